// ===== rtl/amt_pkg.sv =====
// shared constants, types and helper functions for the adaptive mean threshold block
package amt_pkg;

  localparam int MAX_WIDTH       = 512;
  localparam int MAX_HEIGHT      = 512;
  localparam int MAX_WINDOW_TENS = 15;
  localparam int TEN             = 10;
  localparam int WHITE           = 255;

  localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int N_MAX    = MAX_WINDOW_TENS * TEN;
  localparam int CDW      = $clog2(MAX_DIM);                  // coordinate
  localparam int WW       = $clog2(MAX_DIM + 1);              // effective frame size
  localparam int AW       = $clog2(MAX_WIDTH * MAX_HEIGHT);   // store address
  localparam int TW       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int NW       = $clog2(N_MAX + 1);
  localparam int NNW      = $clog2(N_MAX * N_MAX + 1);
  localparam int SUM_W    = $clog2(N_MAX * N_MAX * 255 + 1);
  localparam int CW       = $clog2(MAX_DIM + N_MAX) + 1;      // signed coordinate
  localparam int DVD_W    = (SUM_W > AW) ? SUM_W : AW;
  localparam int DVS_W    = (NNW > WW) ? NNW : WW;
  localparam int CFG_DW   = 10;
  localparam int CFG_IW   = 3;
  localparam int PIX_W    = 8;

  typedef enum logic [CFG_IW-1:0] {
    REG_MODE   = 3'd0,
    REG_LEVEL  = 3'd1,
    REG_WINDOW = 3'd2,
    REG_OFFSET = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_e;

  // clamp a signed coordinate into 0 .. lim-1
  function automatic logic [CDW-1:0] clamp_crd(logic signed [CW-1:0] v, logic [WW-1:0] lim);
    logic [CW-1:0] u;
    u = v;
    if (v[CW-1]) return '0;
    else if (u >= CW'(lim)) return CDW'(lim - 1'b1);
    else return CDW'(u);
  endfunction

  // four-sample average, round half to even
  function automatic logic [PIX_W-1:0] avg4_even(logic [PIX_W+1:0] s);
    logic [PIX_W-1:0] q;
    q = s[PIX_W+1:2];
    if (s[1:0] == 2'd3 || (s[1:0] == 2'd2 && q[0])) q = q + 1'b1;
    return q;
  endfunction

endpackage

// ===== rtl/amt_ram.sv =====
// generic simple dual-port ram with registered read
module amt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/amt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module amt_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [amt_pkg::DVD_W-1:0] dividend_i,
  input  logic [amt_pkg::DVS_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [amt_pkg::DVD_W-1:0] quot_o,
  output logic [amt_pkg::DVS_W-1:0] rem_o
);
  import amt_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d, rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/adaptive_mean_threshold.sv =====
// adaptive mean threshold top level: frame store, window sequencer and result register
//
// input channel (in_valid_i / in_stall_o) carries action_i and pixel_in_i. a load
// beat (action 0) writes the pixel at the next raster position.
// a result beat (action 1) gives one beat on the output channel (out_valid_o /
// out_stall_i) with pixel_out_o and frame_done_o.
// global mode: a result needs one frame store read and a compare.
// adaptive mode: a result sums N*N window samples, N being the window side. its time
// is set by the single read port of the frame store: every window sample needs four
// reads, one per cycle, and the divider gives one quotient bit per cycle for x/y and
// for the mean.
// one item is in work at a time; in_stall_o is high while it is, and for the cycle
// after a register write while the derived frame sizes settle.
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; always
// ready, write only while idle. reset clears positions and registers (frame size
// 512 by 512); the frame store content is undefined until loaded.
// a finished result sits in the output register while the next item is accepted;
// the block waits for the register to empty before it places a new result.
module adaptive_mean_threshold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [amt_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [amt_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          frame_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [amt_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [amt_pkg::CFG_DW-1:0]    cfg_data_i
);
  import amt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_POS    = 10'b0000000010,
    S_PIX    = 10'b0000000100,
    S_DIVXY  = 10'b0000001000,
    S_ROW    = 10'b0000010000,
    S_RD     = 10'b0000100000,
    S_DRAIN  = 10'b0001000000,
    S_MSTART = 10'b0010000000,
    S_DIVM   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic              mode_q;
  logic [7:0]        level_q;
  logic [3:0]        tens_q, offset_q;
  logic [CFG_DW-1:0] fw_q, fh_q;
  logic              cfg_hold_q;

  // derived frame and window sizes, registered: w_q, h_q, n_q from the registers, total_q, half_q, nn_q from those
  logic [WW-1:0]  w_q, h_q, w_e, h_e;
  logic [TW-1:0]  total_q;
  logic [NW-1:0]  n_q, half_q;
  logic [NNW-1:0] nn_q;
  logic [3:0]     tens_e;

  logic             action_q;
  logic [PIX_W-1:0] pin_q, p_q;
  logic [AW-1:0]    lp_q, lp_d, rp_q, rp_d, pos_q, pos_c, lpos_c;
  logic [CDW-1:0]   x_q, y_q;
  logic [NW-1:0]    k_q, l_q;
  logic [1:0]       ph_q;
  logic [AW-1:0]    ra_q, rb_q;
  logic             rv_q, rlast_q;
  logic [PIX_W+1:0] s4_q;
  logic [SUM_W-1:0] sum_q;
  logic             white_q;

  logic             out_valid_q;
  logic [PIX_W-1:0] pout_q;
  logic             fdone_q;
  logic             out_free;

  logic                 we;
  logic [AW-1:0]        raddr, rd_addr;
  logic [PIX_W-1:0]     rdata;
  logic signed [CW-1:0] cola_v, colb_v, rowa_v, rowb_v;
  logic [CDW-1:0]       cola, colb, rowa, rowb;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs, div_rem;

  logic in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE) || cfg_hold_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      level_q  <= '0;
      tens_q   <= '0;
      offset_q <= '0;
      fw_q     <= CFG_DW'(512);
      fh_q     <= CFG_DW'(512);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_LEVEL:  level_q  <= cfg_data_i[7:0];
        REG_WINDOW: tens_q   <= cfg_data_i[3:0];
        REG_OFFSET: offset_q <= cfg_data_i[3:0];
        REG_WIDTH:  fw_q     <= cfg_data_i;
        REG_HEIGHT: fh_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // out-of-range sizes saturate, zero counts as one
  always_comb begin
    if (fw_q == '0) w_e = WW'(1);
    else if (int'(fw_q) > MAX_WIDTH) w_e = WW'(MAX_WIDTH);
    else w_e = WW'(fw_q);
    if (fh_q == '0) h_e = WW'(1);
    else if (int'(fh_q) > MAX_HEIGHT) h_e = WW'(MAX_HEIGHT);
    else h_e = WW'(fh_q);
    if (tens_q == '0) tens_e = 4'd1;
    else if (int'(tens_q) > MAX_WINDOW_TENS) tens_e = 4'(MAX_WINDOW_TENS);
    else tens_e = tens_q;
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_e;
    h_q     <= h_e;
    total_q <= TW'(w_q) * TW'(h_q);
    n_q     <= NW'(tens_e) * NW'(TEN);
    half_q  <= n_q >> 1;
    nn_q    <= NNW'(n_q) * NNW'(n_q);
  end

  assign pos_c  = (TW'(rp_q) >= total_q) ? '0 : rp_q;
  assign lpos_c = (TW'(lp_q) >= total_q) ? '0 : lp_q;

  // window sample coordinates
  always_comb begin
    cola_v = $signed(CW'(x_q)) - $signed(CW'(half_q)) + $signed(CW'(k_q));
    colb_v = cola_v + CW'(1);
    rowa_v = $signed(CW'(y_q)) - $signed(CW'(half_q)) + $signed(CW'(l_q));
    rowb_v = rowa_v + CW'(1);
    cola   = clamp_crd(cola_v, w_q);
    colb   = clamp_crd(colb_v, w_q);
    rowa   = clamp_crd(rowa_v, h_q);
    rowb   = clamp_crd(rowb_v, h_q);
    rd_addr = (ph_q[1] ? rb_q : ra_q) + AW'(ph_q[0] ? colb : cola);
  end

  assign we    = (state_q == S_POS) && !action_q;
  assign raddr = (state_q == S_POS) ? pos_c : rd_addr;

  amt_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(lpos_c),
    .wdata_i(pin_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    div_start = (state_q == S_PIX && mode_q) || (state_q == S_MSTART);
    div_dvd   = (state_q == S_PIX) ? DVD_W'(pos_q) : DVD_W'(sum_q);
    div_dvs   = (state_q == S_PIX) ? DVS_W'(w_q) : DVS_W'(nn_q);
  end

  amt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d = state_q;
    lp_d    = lp_q;
    rp_d    = rp_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_POS;
      S_POS: begin
        if (!action_q) begin
          lp_d    = (TW'(lpos_c) + TW'(1) >= total_q) ? '0 : lpos_c + 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_PIX;
        end
      end
      S_PIX:    state_d = mode_q ? S_DIVXY : S_OUT;
      S_DIVXY:  if (div_done) state_d = S_ROW;
      S_ROW:    state_d = S_RD;
      S_RD: begin
        if (ph_q == 2'd3 && k_q == n_q - 1'b1)
          state_d = (l_q == n_q - 1'b1) ? S_DRAIN : S_ROW;
      end
      S_DRAIN:  state_d = S_MSTART;
      S_MSTART: state_d = S_DIVM;
      S_DIVM:   if (div_done) state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          rp_d    = (TW'(pos_q) + TW'(1) == total_q) ? '0 : pos_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lp_q        <= '0;
      rp_q        <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_hold_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      lp_q       <= lp_d;
      rp_q       <= rp_d;
      rv_q       <= (state_q == S_RD);
      cfg_hold_q <= cfg_valid_i && cfg_ready_o;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= action_i;
      pin_q    <= pixel_in_i;
    end
    if (state_q == S_POS) pos_q <= pos_c;
    if (state_q == S_PIX) begin
      p_q     <= rdata;
      white_q <= rdata > level_q;
    end
    if (state_q == S_DIVXY && div_done) begin
      x_q   <= CDW'(div_rem);
      y_q   <= CDW'(div_quot);
      k_q   <= '0;
      l_q   <= '0;
      sum_q <= '0;
      s4_q  <= '0;
    end
    if (state_q == S_ROW) begin
      ra_q <= AW'(rowa) * AW'(w_q);
      rb_q <= AW'(rowb) * AW'(w_q);
      ph_q <= '0;
    end
    if (state_q == S_RD) begin
      ph_q    <= ph_q + 1'b1;
      rlast_q <= (ph_q == 2'd3);
      if (ph_q == 2'd3) begin
        if (k_q == n_q - 1'b1) begin
          k_q <= '0;
          l_q <= l_q + 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
    // read data lands in the cycle after the address is issued, flagged by rv_q
    if (rv_q) begin
      if (rlast_q) begin
        sum_q <= sum_q + SUM_W'(avg4_even(s4_q + (PIX_W+2)'(rdata)));
        s4_q  <= '0;
      end else begin
        s4_q <= s4_q + (PIX_W+2)'(rdata);
      end
    end
    if (state_q == S_DIVM && div_done)
      white_q <= (PIX_W+1)'(div_quot[PIX_W-1:0]) < (PIX_W+1)'(p_q) + (PIX_W+1)'(offset_q);
    if (state_q == S_OUT && out_free) begin
      pout_q  <= white_q ? PIX_W'(WHITE) : '0;
      fdone_q <= (TW'(pos_q) + TW'(1) == total_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pout_q;
  assign frame_done_o = fdone_q;

  a_rv_from_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(state_q == S_RD))
    else $error("read beat without a read issue");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVXY || state_q == S_DIVM))
    else $error("divider finished outside a wait state");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not placed in output register");

endmodule

// ===== tb/sv/adaptive_mean_threshold_tb.sv =====
// self-checking testbench for the adaptive mean threshold block
module adaptive_mean_threshold_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import amt_pkg::*;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_RESULT = 1'b1;
  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STALL_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             done;
  } thr_result_t;

  typedef struct {
    logic             act;
    logic [PIX_W-1:0] pix;
    bit               typed;
    logic [PIX_W-1:0] want_pix;
    logic             want_done;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i, in_stall_o, action_i;
  logic [PIX_W-1:0] pixel_in_i;
  logic out_valid_o, out_stall_i;
  logic [PIX_W-1:0] pixel_out_o;
  logic frame_done_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  adaptive_mean_threshold u_top (.*);

  // predictor state
  logic [PIX_W-1:0] pix_mem [STORE_DEPTH];
  bit               pix_written [STORE_DEPTH];
  int unsigned      load_pos, res_pos;
  logic             mode_r;
  logic [7:0]       level_r;
  logic [3:0]       tens_r, offset_r;
  logic [9:0]       width_r, height_r;
  int               unwritten;

  thr_result_t pending_q[$];
  int  n_fail;
  int  send_idle_pct, recv_idle_pct;
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_w();
    if (width_r == 10'd0) return 1;
    if (int'(width_r) > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_r);
  endfunction

  function automatic int unsigned eff_h();
    if (height_r == 10'd0) return 1;
    if (int'(height_r) > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_r);
  endfunction

  function automatic int clamp_to(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  function automatic int unsigned window_mean(int x, int y, int w, int h);
    int unsigned tens, s, q, acc;
    int n, half, ra, rb, ca, cb;
    tens = (tens_r == 4'd0) ? 1 : 32'(tens_r);
    if (tens > MAX_WINDOW_TENS) tens = MAX_WINDOW_TENS;
    n = int'(tens) * TEN;
    half = n / 2;
    acc = 0;
    for (int l = 0; l < n; l++) begin
      ra = clamp_to(y - half + l, h) * w;
      rb = clamp_to(y - half + l + 1, h) * w;
      for (int k = 0; k < n; k++) begin
        ca = clamp_to(x - half + k, w);
        cb = clamp_to(x - half + k + 1, w);
        s = 32'(pix_mem[ra+ca]) + 32'(pix_mem[ra+cb]) + 32'(pix_mem[rb+ca]) +
            32'(pix_mem[rb+cb]);
        q = s >> 2;
        // half way rounds to the even neighbour
        if ((s & 3) == 3 || ((s & 3) == 2 && q[0])) q++;
        acc += q;
      end
    end
    return acc / (n * n);
  endfunction

  function automatic void count_unwritten();
    int unsigned total;
    total = eff_w() * eff_h();
    unwritten = 0;
    for (int unsigned i = 0; i < total; i++)
      if (!pix_written[i]) unwritten++;
  endfunction

  // a result may be asked for only when every pixel it reads has been loaded
  function automatic bit result_ready();
    int unsigned pos;
    pos = (res_pos >= eff_w() * eff_h()) ? 0 : res_pos;
    if (mode_r == 1'b0) return pix_written[pos];
    return unwritten == 0;
  endfunction

  // advance the predictor by one accepted beat; returns 1 when a result is due
  function automatic bit predict_beat(logic act, logic [PIX_W-1:0] pin,
                                      output thr_result_t res);
    int unsigned w, h, total, pos, m;
    logic [PIX_W-1:0] p;
    bit white;
    w = eff_w();
    h = eff_h();
    total = w * h;
    res = '0;
    if (act == ACT_LOAD) begin
      if (load_pos >= total) load_pos = 0;
      pix_mem[load_pos] = pin;
      if (!pix_written[load_pos]) begin
        pix_written[load_pos] = 1'b1;
        unwritten--;
      end
      load_pos++;
      if (load_pos >= total) load_pos = 0;
      return 1'b0;
    end
    if (res_pos >= total) res_pos = 0;
    pos = res_pos;
    p = pix_mem[pos];
    if (mode_r == 1'b0) begin
      white = p > level_r;
    end else begin
      m = window_mean(pos % w, pos / w, w, h);
      white = (int'(m) - int'(p)) < int'(offset_r);
    end
    res.pix = white ? PIX_W'(WHITE) : '0;
    res.done = (pos + 1 == total);
    res_pos = pos + 1;
    if (res_pos >= total) res_pos = 0;
    return 1'b1;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DW'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MODE:   mode_r   = val[0];
      REG_LEVEL:  level_r  = val[7:0];
      REG_WINDOW: tens_r   = val[3:0];
      REG_OFFSET: offset_r = val[3:0];
      REG_WIDTH:  width_r  = val[9:0];
      REG_HEIGHT: height_r = val[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_frame(int unsigned mode, int unsigned lvl, int unsigned tens,
                           int unsigned off, int unsigned w, int unsigned h);
    // loads give no result, so let the last one settle first
    wait_drained();
    repeat (10) @(posedge clk_i);
    write_reg(REG_MODE, mode);
    write_reg(REG_LEVEL, lvl);
    write_reg(REG_WINDOW, tens);
    write_reg(REG_OFFSET, off);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    count_unwritten();
  endtask

  task automatic send_beat(logic act, logic [PIX_W-1:0] pin, bit typed,
                           thr_result_t typed_res);
    thr_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pixel_in_i <= pin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_beat(act, pin, res)) pending_q.push_back(typed ? typed_res : res);
  endtask

  task automatic run_random(int results_wanted, bit hold_off);
    int got;
    logic act;
    got = 0;
    while (got < results_wanted) begin
      act = (result_ready() && $urandom_range(99) < 60) ? ACT_RESULT : ACT_LOAD;
      if (hold_off && got == results_wanted / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
        hold_off = 1'b0;
      end
      send_beat(act, PIX_W'($urandom_range(0, 255)), 1'b0, '0);
      if (act == ACT_RESULT) got++;
    end
  endtask

  // output beat checker
  always @(posedge clk_i) begin
    thr_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat pixel_out %0d frame_done %0b",
                 $time, pixel_out_o, frame_done_o);
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (pixel_out_o !== want.pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, want.pix, pixel_out_o);
          n_fail++;
        end
        if (frame_done_o !== want.done) begin
          $display("%0t: frame_done expected %0b actual %0b", $time, want.done,
                   frame_done_o);
          n_fail++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on beats of any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("adaptive_mean_threshold_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  stim_row_t rows[$];

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 64;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_LOAD;
    pixel_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MODE;
    cfg_data_i = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      pix_mem[i] = '0;
      pix_written[i] = 1'b0;
    end
    load_pos = 0;
    res_pos = 0;
    mode_r = 1'b0;
    level_r = '0;
    tens_r = '0;
    offset_r = '0;
    width_r = 10'd512;
    height_r = 10'd512;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3 by 2 frame, global level 128, then a wrap of the result position
    set_frame(0, 128, 0, 0, 3, 2);
    rows = '{
      '{ACT_LOAD, 8'd0, 1'b0, 8'd0, 1'b0}, '{ACT_LOAD, 8'd255, 1'b0, 8'd0, 1'b0},
      '{ACT_LOAD, 8'd128, 1'b0, 8'd0, 1'b0}, '{ACT_LOAD, 8'd129, 1'b0, 8'd0, 1'b0},
      '{ACT_LOAD, 8'd127, 1'b0, 8'd0, 1'b0}, '{ACT_LOAD, 8'd1, 1'b0, 8'd0, 1'b0},
      '{ACT_RESULT, 8'd0, 1'b1, 8'd0, 1'b0}, '{ACT_RESULT, 8'hff, 1'b1, 8'd255, 1'b0},
      '{ACT_RESULT, 8'd0, 1'b1, 8'd0, 1'b0}, '{ACT_RESULT, 8'd0, 1'b1, 8'd255, 1'b0},
      '{ACT_RESULT, 8'd0, 1'b1, 8'd0, 1'b0}, '{ACT_RESULT, 8'd0, 1'b1, 8'd0, 1'b1},
      '{ACT_RESULT, 8'd0, 1'b1, 8'd0, 1'b0}, '{ACT_LOAD, 8'd200, 1'b0, 8'd0, 1'b0},
      '{ACT_RESULT, 8'd0, 1'b0, 8'd0, 1'b0}
    };
    foreach (rows[i])
      send_beat(rows[i].act, rows[i].pix, rows[i].typed,
                '{pix: rows[i].want_pix, done: rows[i].want_done});
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    // zero width taken as one
    set_frame(0, 0, 0, 0, 0, 1);
    run_random(6, 1'b0);
    in_valid_i <= 1'b0;
    // oversized width saturates to the maximum
    set_frame(0, 255, 0, 0, 1023, 1);
    run_random(10, 1'b1);
    in_valid_i <= 1'b0;

    send_idle_pct = 64;
    recv_idle_pct = 13;
    set_frame(1, 0, 0, 0, 5, 4);
    write_reg(REG_SPARE_LO, 10'h3ff);
    write_reg(REG_SPARE_HI, 10'h155);
    run_random(15, 1'b0);
    in_valid_i <= 1'b0;
    set_frame(1, 0, 1, 10, 8, 3);
    run_random(10, 1'b0);
    in_valid_i <= 1'b0;

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // widest window, offset beyond its nominal range
    set_frame(1, 0, 15, 15, 4, 4);
    run_random(2, 1'b0);
    in_valid_i <= 1'b0;
    // single column frame, reusing the entries written above
    set_frame(1, 0, 3, 5, 1, 24);
    run_random(6, 1'b0);
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("adaptive_mean_threshold_tb OK");
    end else begin
      $display("adaptive_mean_threshold_tb NOT OK");
    end
    $finish;
  end

endmodule
